[hw/rtl/i2cbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

    // Command codes carried on the input stream.
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_READ     = 3'd4,
        OP_RESTART  = 3'd5,
        OP_UNSTICK  = 3'd6
    } op_t;

    // Sequencer steps.
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_S1, PH_S2, PH_S3,
        PH_P1, PH_P2, PH_P3,
        PH_WLOW, PH_WHIGH, PH_WACKLOW, PH_WACKHI1, PH_WACKHI2,
        PH_RLOW, PH_RHIGH, PH_RACKLOW, PH_RACKHI,
        PH_RS1, PH_RS2, PH_RS3, PH_RS4,
        PH_U0, PH_UL, PH_UH, PH_UP1, PH_UP2, PH_UP3
    } phase_t;

    // Bits in one data byte.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Reset value of the half period register.
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

    // One result word.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       status;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_release;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/i2cbs_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_core
    import i2cbs_pkg::*;
#(
    parameter int UNSTICK_PULSES = 9,
    parameter int DELAY_BITS     = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        read_nack,
    input  wire logic        sda_in,
    input  wire logic [15:0] half_period,
    output result_t          res_next
);

    localparam logic [32:0] DLY_MAX = (33'd1 << DELAY_BITS) - 33'd1;
    localparam logic [3:0]  PULSE_LIMIT = 4'(UNSTICK_PULSES);

    phase_t                phase_reg, phase_next;
    logic [DELAY_BITS-1:0] delay_count_reg, delay_count_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shifter_reg, shifter_next;
    logic [3:0]            pulse_count_reg, pulse_count_next;
    logic                  scl_drive_reg, scl_drive_next;
    logic                  sda_drive_reg, sda_drive_next;
    logic                  ack_flag_reg, ack_flag_next;
    logic                  nack_choice_reg, nack_choice_next;
    logic [7:0]            rx_hold_reg, rx_hold_next;
    logic                  done_next;

    logic [32:0]           hp_ext;
    logic [DELAY_BITS-1:0] h_sat, dly_h, dly_q, dly_e, q_raw, e_raw;
    logic [3:0]            bc_inc, pc_inc;

    // Step delays: H saturated to the counter and kept at least one, Q and E from it.
    always_comb
    begin
        hp_ext = 33'(half_period);
        if (hp_ext > DLY_MAX)
        begin
            h_sat = DLY_MAX[DELAY_BITS-1:0];
        end
        else
        begin
            h_sat = hp_ext[DELAY_BITS-1:0];
        end
        dly_h = (h_sat == '0) ? DELAY_BITS'(1) : h_sat;
        q_raw = dly_h >> 1;
        e_raw = dly_h >> 2;
        dly_q = (q_raw == '0) ? DELAY_BITS'(1) : q_raw;
        dly_e = (e_raw == '0) ? DELAY_BITS'(1) : e_raw;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        delay_count_next = delay_count_reg;
        bit_count_next   = bit_count_reg;
        shifter_next     = shifter_reg;
        pulse_count_next = pulse_count_reg;
        scl_drive_next   = scl_drive_reg;
        sda_drive_next   = sda_drive_reg;
        ack_flag_next    = ack_flag_reg;
        nack_choice_next = nack_choice_reg;
        rx_hold_next     = rx_hold_reg;
        done_next        = 1'b0;
        bc_inc           = bit_count_reg + 4'd1;
        pc_inc           = pulse_count_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            unique case (op_t'(operation))
                OP_START:
                begin
                    sda_drive_next   = 1'b1;
                    scl_drive_next   = 1'b1;
                    phase_next       = PH_S1;
                    delay_count_next = dly_q;
                end
                OP_STOP:
                begin
                    sda_drive_next   = 1'b0;
                    phase_next       = PH_P1;
                    delay_count_next = dly_h;
                end
                OP_WRITE:
                begin
                    bit_count_next   = 4'd0;
                    sda_drive_next   = tx_byte[7];
                    shifter_next     = {tx_byte[6:0], 1'b0};
                    phase_next       = PH_WLOW;
                    delay_count_next = dly_h;
                end
                OP_READ:
                begin
                    nack_choice_next = read_nack;
                    shifter_next     = 8'd0;
                    bit_count_next   = 4'd0;
                    sda_drive_next   = 1'b1;
                    phase_next       = PH_RLOW;
                    delay_count_next = dly_h;
                end
                OP_RESTART:
                begin
                    sda_drive_next   = 1'b1;
                    phase_next       = PH_RS1;
                    delay_count_next = dly_h;
                end
                OP_UNSTICK:
                begin
                    scl_drive_next   = 1'b1;
                    sda_drive_next   = 1'b1;
                    pulse_count_next = 4'd0;
                    phase_next       = PH_U0;
                    delay_count_next = dly_h;
                end
                default:
                begin
                end
            endcase
        end
        else if (delay_count_reg > DELAY_BITS'(1))
        begin
            delay_count_next = delay_count_reg - DELAY_BITS'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_S1:
                begin
                    sda_drive_next = 1'b0;
                    phase_next = PH_S2;
                    delay_count_next = dly_h;
                end
                PH_S2:
                begin
                    scl_drive_next = 1'b0;
                    phase_next = PH_S3;
                    delay_count_next = dly_h;
                end
                PH_P1:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_P2;
                    delay_count_next = dly_q;
                end
                PH_P2:
                begin
                    sda_drive_next = 1'b1;
                    phase_next = PH_P3;
                    delay_count_next = dly_q;
                end
                PH_WLOW:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_WHIGH;
                    delay_count_next = dly_q;
                end
                PH_WHIGH:
                begin
                    scl_drive_next = 1'b0;
                    bit_count_next = bc_inc;
                    if (bc_inc < BYTE_BITS)
                    begin
                        sda_drive_next = shifter_reg[7];
                        shifter_next = {shifter_reg[6:0], 1'b0};
                        phase_next = PH_WLOW;
                    end
                    else
                    begin
                        sda_drive_next = 1'b1;
                        phase_next = PH_WACKLOW;
                    end
                    delay_count_next = dly_h;
                end
                PH_WACKLOW:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_WACKHI1;
                    delay_count_next = dly_e;
                end
                PH_WACKHI1:
                begin
                    ack_flag_next = sda_in;
                    phase_next = PH_WACKHI2;
                    delay_count_next = dly_e;
                end
                PH_WACKHI2:
                begin
                    scl_drive_next = 1'b0;
                    done_next = 1'b1;
                end
                PH_RLOW:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_RHIGH;
                    delay_count_next = dly_q;
                end
                PH_RHIGH:
                begin
                    shifter_next = {shifter_reg[6:0], sda_in};
                    scl_drive_next = 1'b0;
                    bit_count_next = bc_inc;
                    if (bc_inc < BYTE_BITS)
                    begin
                        phase_next = PH_RLOW;
                    end
                    else
                    begin
                        sda_drive_next = nack_choice_reg;
                        phase_next = PH_RACKLOW;
                    end
                    delay_count_next = dly_h;
                end
                PH_RACKLOW:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_RACKHI;
                    delay_count_next = dly_q;
                end
                PH_RACKHI:
                begin
                    scl_drive_next = 1'b0;
                    sda_drive_next = 1'b1;
                    rx_hold_next = shifter_reg;
                    done_next = 1'b1;
                end
                PH_RS1:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_RS2;
                    delay_count_next = dly_h;
                end
                PH_RS2:
                begin
                    sda_drive_next = 1'b0;
                    phase_next = PH_RS3;
                    delay_count_next = dly_h;
                end
                PH_RS3:
                begin
                    scl_drive_next = 1'b0;
                    phase_next = PH_RS4;
                    delay_count_next = dly_h;
                end
                PH_U0:
                begin
                    if (sda_in)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        scl_drive_next = 1'b0;
                        phase_next = PH_UL;
                        delay_count_next = dly_h;
                    end
                end
                PH_UL:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_UH;
                    delay_count_next = dly_h;
                end
                PH_UH:
                begin
                    pulse_count_next = pc_inc;
                    if (sda_in || (pc_inc >= PULSE_LIMIT))
                    begin
                        sda_drive_next = 1'b0;
                        phase_next = PH_UP1;
                    end
                    else
                    begin
                        scl_drive_next = 1'b0;
                        phase_next = PH_UL;
                    end
                    delay_count_next = dly_h;
                end
                PH_UP1:
                begin
                    scl_drive_next = 1'b1;
                    phase_next = PH_UP2;
                    delay_count_next = dly_h;
                end
                PH_UP2:
                begin
                    sda_drive_next = 1'b1;
                    phase_next = PH_UP3;
                    delay_count_next = dly_h;
                end
                default:
                begin
                    // Final wait steps of start, stop and the like simply end.
                    done_next = 1'b1;
                end
            endcase

            if (done_next)
            begin
                phase_next = PH_IDLE;
                delay_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            bit_count_reg   <= 4'd0;
            shifter_reg     <= 8'd0;
            pulse_count_reg <= 4'd0;
            scl_drive_reg   <= 1'b1;
            sda_drive_reg   <= 1'b1;
            ack_flag_reg    <= 1'b0;
            nack_choice_reg <= 1'b0;
            rx_hold_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
            bit_count_reg   <= bit_count_next;
            shifter_reg     <= shifter_next;
            pulse_count_reg <= pulse_count_next;
            scl_drive_reg   <= scl_drive_next;
            sda_drive_reg   <= sda_drive_next;
            ack_flag_reg    <= ack_flag_next;
            nack_choice_reg <= nack_choice_next;
            rx_hold_reg     <= rx_hold_next;
        end
    end

    always_comb
    begin
        res_next.scl_release = scl_drive_next;
        res_next.sda_release = sda_drive_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
        res_next.done_res    = done_next;
        res_next.status      = ack_flag_next;
        res_next.rx_byte     = rx_hold_next;
    end

endmodule

`default_nettype wire

[hw/rtl/i2cbs_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_out_reg
    import i2cbs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    m_tready,
    output logic         m_tvalid,
    output logic         ready,
    output result_t      res_out
);

    logic    valid_reg;
    result_t res_reg;

    // A new word may enter when the slot is empty or is being drained.
    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/i2c_master_byte_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each result word is registered and shows on m_tdata the cycle after its word is taken.
// One word per cycle; s_tready drops only while a held result is stalled.
// Each input word is one timing tick; the sequencer state advances once per word.
// Reset (rst_n low, asynchronous): sequencer idle, both lines released, counters,
// status and received byte cleared, output slot empty, half period set to 250.

module i2c_master_byte_sequencer_unit
    import i2cbs_pkg::*;
#(
    parameter int UNSTICK_PULSES = 9,
    parameter int DELAY_BITS     = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Half period register write port.
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    // Input words, one per timing tick.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata fields from bit 0: tx_byte[7:0], read_nack, sda_in, zero padding.
    input  wire logic [15:0] s_tdata,
    // s_tuser fields from bit 0: operation[2:0].
    input  wire logic [2:0]  s_tuser,

    // Result words, one per input word.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata fields from bit 0: scl_release, sda_release, busy_res, done_res,
    // status, rx_byte[7:0], zero padding.
    output logic [15:0]      m_tdata
);

    // The SCL half period in ticks. It is sampled by the sequencer each time a
    // step loads its delay, so a change mid-command shows at the next step.
    logic [15:0] half_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    // A word is taken whenever the output slot can take its result.
    logic    accept;
    result_t res_next;
    result_t res_out;

    assign accept = s_tvalid && s_tready;

    // The sequencer works out the state after this tick combinationally from
    // the word and its own registers, and commits it on the accept edge.
    i2cbs_core #(
        .UNSTICK_PULSES (UNSTICK_PULSES),
        .DELAY_BITS     (DELAY_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .operation   (s_tuser),
        .tx_byte     (s_tdata[7:0]),
        .read_nack   (s_tdata[8]),
        .sda_in      (s_tdata[9]),
        .half_period (half_period_reg),
        .res_next    (res_next)
    );

    // The output register holds the result while the consumer stalls, and lets
    // the next word in on the same cycle that the held one is taken.
    i2cbs_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res_in   (res_next),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .ready    (s_tready),
        .res_out  (res_out)
    );

    assign m_tdata = {3'b000, res_out.rx_byte, res_out.status, res_out.done_res,
                      res_out.busy_res, res_out.sda_release, res_out.scl_release};

    // A completed command is never reported as still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res_out.done_res && res_out.busy_res))
        else $error("done and busy set in the same result word");

    // Every accepted word leaves a result in the output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    // A stalled result must block new words so it is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while a result is stalled");

    // An empty output slot always lets a word in.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with an empty output slot");

endmodule

`default_nettype wire

[tb/bus_step_checker.sv]
`timescale 1ns / 1ps

// Follows the sequencer one timing tick at a time and checks every result word.
module bus_step_checker
    import i2cbs_pkg::*;
#(
    parameter int UNSTICK_PULSES = 9
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    output int               mismatches,
    output int               words_due,
    output logic             seq_busy
);

    logic [15:0] half_period;
    phase_t      seq_step;
    logic [15:0] wait_left;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [3:0]  pulses;
    logic        scl_rel;
    logic        sda_rel;
    logic        ack_seen;
    logic        end_nack;
    logic [7:0]  rx_last;
    int          errs;
    result_t     want;
    result_t     got;
    result_t     line_states_due[$];

    // A zero half period counts as one tick.
    function automatic logic [15:0] span_half();
        return (half_period == 16'd0) ? 16'd1 : half_period;
    endfunction

    function automatic logic [15:0] span_quarter();
        logic [15:0] v;
        v = span_half() >> 1;
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [15:0] span_eighth();
        logic [15:0] v;
        v = span_half() >> 2;
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    task automatic enter(input phase_t p, input logic [15:0] d);
        seq_step  = p;
        wait_left = d;
    endtask

    task automatic shift_out();
        sda_rel = shifter[7];
        shifter = {shifter[6:0], 1'b0};
    endtask

    // One tick of the sequencer; returns the line and status word that it leaves behind.
    task automatic predict_tick(input logic [2:0] op, input logic [7:0] tx, input logic nack,
                                input logic sda, output result_t r);
        logic done;
        done = 1'b0;
        if (seq_step == PH_IDLE) begin
            case (op)
                OP_START: begin
                    sda_rel = 1'b1;
                    scl_rel = 1'b1;
                    enter(PH_S1, span_quarter());
                end
                OP_STOP: begin
                    sda_rel = 1'b0;
                    enter(PH_P1, span_half());
                end
                OP_WRITE: begin
                    shifter = tx;
                    bit_idx = 4'd0;
                    shift_out();
                    enter(PH_WLOW, span_half());
                end
                OP_READ: begin
                    end_nack = nack;
                    shifter  = 8'd0;
                    bit_idx  = 4'd0;
                    sda_rel  = 1'b1;
                    enter(PH_RLOW, span_half());
                end
                OP_RESTART: begin
                    sda_rel = 1'b1;
                    enter(PH_RS1, span_half());
                end
                OP_UNSTICK: begin
                    scl_rel = 1'b1;
                    sda_rel = 1'b1;
                    pulses  = 4'd0;
                    enter(PH_U0, span_half());
                end
                default: ;
            endcase
        end else if (wait_left > 16'd1) begin
            wait_left = wait_left - 16'd1;
        end else begin
            case (seq_step)
                PH_S1: begin sda_rel = 1'b0; enter(PH_S2, span_half()); end
                PH_S2: begin scl_rel = 1'b0; enter(PH_S3, span_half()); end
                PH_P1: begin scl_rel = 1'b1; enter(PH_P2, span_quarter()); end
                PH_P2: begin sda_rel = 1'b1; enter(PH_P3, span_quarter()); end
                PH_WLOW: begin scl_rel = 1'b1; enter(PH_WHIGH, span_quarter()); end
                PH_WHIGH: begin
                    scl_rel = 1'b0;
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx < BYTE_BITS) begin
                        shift_out();
                        enter(PH_WLOW, span_half());
                    end else begin
                        sda_rel = 1'b1;
                        enter(PH_WACKLOW, span_half());
                    end
                end
                PH_WACKLOW: begin scl_rel = 1'b1; enter(PH_WACKHI1, span_eighth()); end
                PH_WACKHI1: begin ack_seen = sda; enter(PH_WACKHI2, span_eighth()); end
                PH_WACKHI2: begin scl_rel = 1'b0; done = 1'b1; end
                PH_RLOW: begin scl_rel = 1'b1; enter(PH_RHIGH, span_quarter()); end
                PH_RHIGH: begin
                    shifter = {shifter[6:0], sda};
                    scl_rel = 1'b0;
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx < BYTE_BITS) begin
                        enter(PH_RLOW, span_half());
                    end else begin
                        sda_rel = end_nack;
                        enter(PH_RACKLOW, span_half());
                    end
                end
                PH_RACKLOW: begin scl_rel = 1'b1; enter(PH_RACKHI, span_quarter()); end
                PH_RACKHI: begin
                    scl_rel = 1'b0;
                    sda_rel = 1'b1;
                    rx_last = shifter;
                    done    = 1'b1;
                end
                PH_RS1: begin scl_rel = 1'b1; enter(PH_RS2, span_half()); end
                PH_RS2: begin sda_rel = 1'b0; enter(PH_RS3, span_half()); end
                PH_RS3: begin scl_rel = 1'b0; enter(PH_RS4, span_half()); end
                PH_U0: begin
                    // A bus that already reads high needs no clock pulses at all.
                    if (sda) begin
                        done = 1'b1;
                    end else begin
                        scl_rel = 1'b0;
                        enter(PH_UL, span_half());
                    end
                end
                PH_UL: begin scl_rel = 1'b1; enter(PH_UH, span_half()); end
                PH_UH: begin
                    pulses = pulses + 4'd1;
                    if (sda || pulses >= UNSTICK_PULSES) begin
                        sda_rel = 1'b0;
                        enter(PH_UP1, span_half());
                    end else begin
                        scl_rel = 1'b0;
                        enter(PH_UL, span_half());
                    end
                end
                PH_UP1: begin scl_rel = 1'b1; enter(PH_UP2, span_half()); end
                PH_UP2: begin sda_rel = 1'b1; enter(PH_UP3, span_half()); end
                default: done = 1'b1;
            endcase
            if (done) begin
                enter(PH_IDLE, 16'd0);
            end
        end
        r.scl_release = scl_rel;
        r.sda_release = sda_rel;
        r.busy_res    = (seq_step != PH_IDLE);
        r.done_res    = done;
        r.status      = ack_seen;
        r.rx_byte     = rx_last;
    endtask

    task automatic report(input string what, input result_t w, input result_t g);
        errs = errs + 1;
        if (errs <= 10) begin
            $display("%0t ns: %s: expected scl=%0b sda=%0b busy=%0b done=%0b status=%0b rx=%02h",
                     $time, what, w.scl_release, w.sda_release, w.busy_res, w.done_res,
                     w.status, w.rx_byte);
            $display("%0t ns: %s: actual   scl=%0b sda=%0b busy=%0b done=%0b status=%0b rx=%02h",
                     $time, what, g.scl_release, g.sda_release, g.busy_res, g.done_res,
                     g.status, g.rx_byte);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            half_period = HALF_PERIOD_RESET;
            seq_step    = PH_IDLE;
            wait_left   = 16'd0;
            bit_idx     = 4'd0;
            shifter     = 8'd0;
            pulses      = 4'd0;
            scl_rel     = 1'b1;
            sda_rel     = 1'b1;
            ack_seen    = 1'b0;
            end_nack    = 1'b0;
            rx_last     = 8'd0;
            errs        = 0;
            line_states_due.delete();
            mismatches <= 0;
            words_due  <= 0;
            seq_busy   <= 1'b0;
        end else begin
            if (cfg_we) begin
                half_period = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], want);
                line_states_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[12:0];
                if (line_states_due.size() == 0) begin
                    report("result word with no input behind it", '0, got);
                end else begin
                    want = line_states_due.pop_front();
                    if (got.scl_release !== want.scl_release ||
                        got.sda_release !== want.sda_release ||
                        got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res ||
                        got.status !== want.status ||
                        got.rx_byte !== want.rx_byte) begin
                        report("result word mismatch", want, got);
                    end
                end
            end
            mismatches <= errs;
            words_due  <= line_states_due.size();
            seq_busy   <= (seq_step != PH_IDLE);
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the I2C byte sequencer. Every input word is one
// timing tick, so a command is a single word carrying the operation followed by
// filler words that let the sequencer walk through its steps. The checker
// beside the block predicts the line levels and status of every result word.
module testbench;
    import i2cbs_pkg::*;

    localparam int UNSTICK_PULSES = 9;
    localparam int DELAY_BITS     = 16;

    // Operation code seven is not a command; the block treats it like no operation.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // The longest quiet stretch in a correct run is a long sender gap meeting a
    // long receiver stall, or a configuration pause.
    localparam int QUIET_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    wire logic   s_tready;
    // s_tdata fields from bit 0: tx_byte[7:0], read_nack, sda_in, zero padding.
    logic [15:0] s_tdata;
    // s_tuser fields from bit 0: operation[2:0].
    logic [2:0]  s_tuser;
    wire logic   m_tvalid;
    logic        m_tready;
    // m_tdata fields from bit 0: scl_release, sda_release, busy_res, done_res,
    // status, rx_byte[7:0], zero padding.
    wire logic [15:0] m_tdata;

    int   mismatches;
    int   words_due;
    logic seq_busy;

    // When set, both sides insert random gaps and stalls.
    bit idle_on;
    // Percentage of ticks on which the SDA line is sampled high.
    int sda_pct;
    int words_sent;
    int stall_left;
    int quiet;

    i2c_master_byte_sequencer_unit #(
        .UNSTICK_PULSES (UNSTICK_PULSES),
        .DELAY_BITS     (DELAY_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bus_step_checker #(
        .UNSTICK_PULSES (UNSTICK_PULSES)
    ) line_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .words_due  (words_due),
        .seq_busy   (seq_busy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Most gaps are short; now and then one is long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 75)
        begin
            return 0;
        end
        if (r < 97)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // The receiver stalls at random while idling is on and is always ready otherwise.
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = gap_len();
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet = 0;
        end
        else
        begin
            quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Sends one word and returns at the edge where it is taken. The valid is left
    // high so that back-to-back words keep it asserted without a drop.
    task automatic put_word(input logic [2:0] op, input logic [7:0] tx, input logic nack);
        int   gap;
        logic sda_bit;
        gap = idle_on ? gap_len() : 0;
        sda_bit = ($urandom_range(99) < sda_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, sda_bit, nack, tx};
        do @(posedge clk); while (!s_tready);
        words_sent = words_sent + 1;
    endtask

    // Holds back new words until every predicted result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
    endtask

    // Lets the sequencer finish whatever it runs and then empties the output side.
    task automatic settle();
        drain();
        while (seq_busy)
        begin
            repeat (32) put_word(OP_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            drain();
        end
    endtask

    // Feeds filler ticks until the command just sent has been seen running and
    // then idle again. A few filler ticks carry random operations as noise;
    // the sequencer ignores those that arrive while it is busy.
    task automatic finish_command(input int noise_pct);
        bit         seen;
        logic [2:0] op;
        seen = 1'b0;
        while (!seen || seq_busy)
        begin
            if (seq_busy)
            begin
                seen = 1'b1;
            end
            op = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : OP_NONE;
            put_word(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_command(input op_t op, input logic [7:0] tx, input logic nack,
                               input int noise_pct);
        put_word(op, tx, nack);
        finish_command(noise_pct);
    endtask

    // The register is only written with the sequencer idle and no result pending.
    task automatic set_half_period(input logic [15:0] value);
        settle();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A typical transfer: start, address and data writes, sometimes a repeated
    // start with reads ending in NACK, and a stop.
    task automatic transfer();
        int n;
        int k;
        sda_pct = 50;
        run_command(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
        n = $urandom_range(1, 3);
        repeat (n) run_command(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
        if ($urandom_range(1))
        begin
            run_command(OP_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
            run_command(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
            n = $urandom_range(1, 2);
            for (k = 1; k <= n; k++)
            begin
                run_command(OP_READ, 8'($urandom_range(255)), (k == n), 5);
            end
        end
        run_command(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
    endtask

    task automatic random_phase(input int budget);
        int stop_at;
        int r;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 75)
            begin
                transfer();
            end
            else if (r < 85)
            begin
                // Recovery with SDA held low for a random while, or not at all.
                case ($urandom_range(3))
                    0: sda_pct = 0;
                    1: sda_pct = 10;
                    2: sda_pct = 50;
                    default: sda_pct = 100;
                endcase
                run_command(OP_UNSTICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 5);
            end
            else if (r < 95)
            begin
                // Broken sequences: lone commands out of order and raw noise words.
                sda_pct = 50;
                run_command(op_t'($urandom_range(1, 6)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), 20);
                repeat ($urandom_range(1, 6))
                    put_word(3'($urandom_range(7)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
            end
            else
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 16'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 16'd0;
        s_tuser    = OP_NONE;
        m_tready   = 1'b0;
        idle_on    = 1'b1;
        sda_pct    = 50;
        words_sent = 0;
        stall_left = 0;
        quiet      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset half period of 250 ticks: an unstick on a free bus waits one full H.
        sda_pct = 100;
        run_command(OP_UNSTICK, 8'h00, 1'b0, 0);
        sda_pct = 50;

        // Directed commands with a zero half period, which runs as one tick.
        set_half_period(16'd0);
        put_word(OP_UNUSED, 8'hFF, 1'b1);
        run_command(OP_START, 8'h00, 1'b0, 0);
        sda_pct = 0;
        run_command(OP_WRITE, 8'h00, 1'b0, 0);
        sda_pct = 100;
        run_command(OP_WRITE, 8'hFF, 1'b1, 0);
        // A write that lands while the start is still running must be dropped.
        sda_pct = 50;
        put_word(OP_START, 8'h00, 1'b0);
        put_word(OP_WRITE, 8'hA5, 1'b0);
        finish_command(0);
        sda_pct = 100;
        run_command(OP_READ, 8'h00, 1'b0, 0);
        sda_pct = 0;
        run_command(OP_READ, 8'hFF, 1'b1, 0);
        sda_pct = 50;
        run_command(OP_RESTART, 8'h5A, 1'b0, 0);
        run_command(OP_READ, 8'h3C, 1'b1, 0);
        run_command(OP_STOP, 8'h00, 1'b0, 0);
        // Unstick: SDA stuck low for every pulse, SDA already high, and in between.
        sda_pct = 0;
        run_command(OP_UNSTICK, 8'h00, 1'b0, 0);
        sda_pct = 100;
        run_command(OP_UNSTICK, 8'hFF, 1'b1, 0);
        sda_pct = 20;
        run_command(OP_UNSTICK, 8'h81, 1'b0, 0);
        sda_pct = 50;
        run_command(OP_STOP, 8'h7E, 1'b1, 0);

        // Random traffic over several short half periods, one phase with no idling.
        set_half_period(16'd1);
        idle_on = 1'b1;
        random_phase(90);
        set_half_period(16'd2);
        random_phase(90);
        set_half_period(16'd3);
        idle_on = 1'b0;
        random_phase(90);
        set_half_period(16'd4);
        idle_on = 1'b1;
        random_phase(90);
        set_half_period(16'd7);
        random_phase(60);
        set_half_period(16'($urandom_range(5, 12)));
        random_phase(60);

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/i2cbs_pkg.sv
hw/rtl/i2cbs_core.sv
hw/rtl/i2cbs_out_reg.sv
hw/rtl/i2c_master_byte_sequencer_unit.sv
tb/bus_step_checker.sv
tb/testbench.sv
